[design/lpd_pkg.sv]
// shared types and constants of the long press and drag detector
package lpd_pkg;

    localparam int POS_W      = 16;
    localparam int BTN_W      = 8;
    localparam int CLICK_W    = 4;
    localparam int RADIUS_W   = 12;
    localparam int RADIUS_SQ_W = 2 * RADIUS_W;
    localparam int TICK_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 12'd4;
    localparam logic [TICK_W-1:0]   DURATION_RESET = 16'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'd1;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_DOWN = 2'd1,
        OP_UP   = 2'd2,
        OP_MOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        GESTURE_NONE = 2'd0,
        GESTURE_LONG = 2'd1,
        GESTURE_DRAG = 2'd2
    } gesture_t;

    typedef struct packed {
        op_t                       opcode;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic [BTN_W-1:0]          button_mask;
        logic [CLICK_W-1:0]        click_count;
    } event_t;

    typedef struct packed {
        gesture_t                  gesture;
        logic signed [POS_W-1:0]   origin_x;
        logic signed [POS_W-1:0]   origin_y;
        logic [BTN_W-1:0]          gesture_buttons;
        logic [BTN_W-1:0]          released_buttons;
    } result_t;

    typedef struct packed {
        logic [RADIUS_SQ_W-1:0]    radius_sq;
        logic [TICK_W-1:0]         duration;
    } cfg_t;

endpackage

[design/long_press_and_drag_detector.sv]
// long press and drag detector top level
//
// usage:
//   evt channel (evt_valid, evt_stall, evt) carries pointer events and ticks
//   res channel (res_valid, res_stall, res) returns exactly one result per event
//   a transaction happens on a rising edge with valid high and stall low
//   cfg_write with cfg_index and cfg_data writes the drag radius (index 0)
//   or the long press duration in ticks (index 1); write only while idle (not enforced)
// timing:
//   an event waits in the input register, then its result is loaded into the
//   result register
//   one event per cycle is sustained while res is not stalled; all work is one pass through the
//   distance squarers and the tick compare
// reset:
//   tracking disarmed, position, buttons and tick count cleared,
//   radius 4 and duration 500
// stall:
//   a stalled result holds; the input register still takes one more event,
//   and evt_stall rises only when both registers are full
module long_press_and_drag_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             evt_valid,
    output logic                             evt_stall,
    input  lpd_pkg::event_t                  evt,
    output logic                             res_valid,
    input  logic                             res_stall,
    output lpd_pkg::result_t                 res,
    input  logic                             cfg_write,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lpd_pkg::*;

    cfg_t    cfg;
    event_t  evt_q_reg;
    logic    evt_q_valid_reg, evt_q_valid_next;
    result_t res_reg;
    result_t core_res;
    logic    res_valid_reg, res_valid_next;
    logic    advance;

    lpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .ev    (evt_q_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    assign advance   = evt_q_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall = evt_q_valid_reg && !advance;

    always_comb
    begin
        evt_q_valid_next = evt_q_valid_reg;
        if (evt_valid && !evt_stall)
            evt_q_valid_next = 1'b1;
        else if (advance)
            evt_q_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_q_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            evt_q_valid_reg <= evt_q_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && !evt_stall)
            evt_q_reg <= evt;
        if (advance)
            res_reg <= core_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // no gesture means no origin and no gesture buttons
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.gesture == GESTURE_NONE |->
            res.origin_x == '0 && res.origin_y == '0 && res.gesture_buttons == '0)
        else $error("idle result carries gesture fields");

    // released buttons only come without a gesture
    a_release_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.released_buttons != '0 |-> res.gesture == GESTURE_NONE)
        else $error("release reported together with a gesture");

    // an event in the input register moves on whenever the result side is free
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        evt_q_valid_reg && !res_valid |=> res_valid)
        else $error("event held back with result register empty");

endmodule

[design/lpd_cfg.sv]
// configuration registers with the squared drag radius kept ready
module lpd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lpd_pkg::cfg_t                    cfg
);
    import lpd_pkg::*;

    logic [RADIUS_W-1:0]    radius;
    logic [RADIUS_SQ_W-1:0] radius_sq_reg;
    logic [TICK_W-1:0]      duration_reg;

    assign radius = cfg_data[RADIUS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= RADIUS_SQ_W'(RADIUS_RESET * RADIUS_RESET);
            duration_reg  <= DURATION_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RADIUS:   radius_sq_reg <= {{RADIUS_W{1'b0}}, radius}
                                             * {{RADIUS_W{1'b0}}, radius};
                CFG_DURATION: duration_reg  <= cfg_data[TICK_W-1:0];
            endcase
        end
    end

    assign cfg.radius_sq = radius_sq_reg;
    assign cfg.duration  = duration_reg;

endmodule

[design/lpd_core.sv]
// tracking state and gesture decision for one event
module lpd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lpd_pkg::event_t  ev,
    input  lpd_pkg::cfg_t    cfg,
    output lpd_pkg::result_t res
);
    import lpd_pkg::*;

    logic                    armed_reg, armed_next;
    logic signed [POS_W-1:0] click_x_reg, click_x_next;
    logic signed [POS_W-1:0] click_y_reg, click_y_next;
    logic [BTN_W-1:0]        held_reg, held_next;
    logic [BTN_W-1:0]        armed_btn_reg, armed_btn_next;
    logic [TICK_W-1:0]       elapsed_reg, elapsed_next;

    logic [TICK_W-1:0]       tick_inc;
    logic signed [POS_W:0]   dx, dy;
    logic [POS_W-1:0]        adx, ady;
    logic [2*POS_W-1:0]      sqx, sqy;
    logic [2*POS_W:0]        dist_sq;
    logic                    reach;

    // squared distance from the click point
    assign dx   = {click_x_reg[POS_W-1], click_x_reg} - {ev.pos_x[POS_W-1], ev.pos_x};
    assign dy   = {click_y_reg[POS_W-1], click_y_reg} - {ev.pos_y[POS_W-1], ev.pos_y};
    assign adx  = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    assign ady  = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    assign sqx  = adx * adx;
    assign sqy  = ady * ady;
    assign dist_sq = {1'b0, sqx} + {1'b0, sqy};
    assign reach = dist_sq >= (2*POS_W+1)'(cfg.radius_sq);

    assign tick_inc = (elapsed_reg == {TICK_W{1'b1}}) ? elapsed_reg
                                                       : elapsed_reg + TICK_W'(1);

    always_comb
    begin
        armed_next     = armed_reg;
        click_x_next   = click_x_reg;
        click_y_next   = click_y_reg;
        held_next      = held_reg;
        armed_btn_next = armed_btn_reg;
        elapsed_next   = elapsed_reg;
        res            = '0;
        res.gesture    = GESTURE_NONE;
        unique case (ev.opcode)
            OP_TICK:
            begin
                if (armed_reg)
                begin
                    elapsed_next = tick_inc;
                    if (tick_inc >= cfg.duration)
                    begin
                        res.gesture         = GESTURE_LONG;
                        res.origin_x        = click_x_reg;
                        res.origin_y        = click_y_reg;
                        res.gesture_buttons = armed_btn_reg;
                        armed_next          = 1'b0;
                    end
                end
            end
            OP_DOWN:
            begin
                held_next = ev.button_mask;
                if (ev.button_mask != '0 && ev.click_count == CLICK_W'(1))
                begin
                    armed_next     = 1'b1;
                    click_x_next   = ev.pos_x;
                    click_y_next   = ev.pos_y;
                    elapsed_next   = '0;
                    armed_btn_next = ev.button_mask;
                end
            end
            OP_UP:
            begin
                armed_next           = 1'b0;
                res.released_buttons = held_reg;
                held_next            = ev.button_mask;
            end
            OP_MOVE:
            begin
                if (armed_reg && reach)
                begin
                    res.gesture         = GESTURE_DRAG;
                    res.origin_x        = click_x_reg;
                    res.origin_y        = click_y_reg;
                    res.gesture_buttons = held_reg;
                    armed_next          = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            click_x_reg   <= '0;
            click_y_reg   <= '0;
            held_reg      <= '0;
            armed_btn_reg <= '0;
            elapsed_reg   <= '0;
        end
        else if (fire)
        begin
            armed_reg     <= armed_next;
            click_x_reg   <= click_x_next;
            click_y_reg   <= click_y_next;
            held_reg      <= held_next;
            armed_btn_reg <= armed_btn_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    // a reported gesture always ends tracking
    a_gesture_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.gesture != GESTURE_NONE |=> !armed_reg)
        else $error("tracking still armed after a gesture report");

    // a button up never leaves tracking armed
    a_up_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ev.opcode == OP_UP |=> !armed_reg)
        else $error("tracking still armed after button up");

    // a drag needs an armed tracker and a move
    a_drag_source: assert property (@(posedge clk) disable iff (!rst_n)
        res.gesture == GESTURE_DRAG |-> armed_reg && ev.opcode == OP_MOVE)
        else $error("drag reported without armed move");

endmodule
